/* src/rle_count_string_encoder_core_assert.svh */
// assertion macros for the run-length count encoder controller
// expects clk and rst_n in the scope where a macro is used
`ifndef RLE_COUNT_STRING_ENCODER_CORE_ASSERT_SVH
`define RLE_COUNT_STRING_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLECSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlecse: same-cycle check failed");

// next-cycle implication, checked outside reset
`define RLECSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlecse: next-cycle check failed");

`endif

/* src/rlecse_pkg.sv */
// shared types and constants of the run-length count string encoder
// no dependencies
`default_nettype none

package rlecse_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned GROUP_BITS     = 5;
  localparam logic [6:0]  CHAR_BASE      = 7'd48;
  localparam logic [1:0]  POS_SAT        = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a new count
    logic emit;   // write one character to the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;   // groups remain after the current one
  } dp_sts_t;

endpackage

`default_nettype wire

/* src/rle_count_string_encoder_core.sv */
// a taken count loads the shift register; its characters are registered for output one by one
// throughput: one character per cycle when the output does not stall, n characters per count
// (1 to 5 at 24-bit counts); the next count is taken in the cycle of the last character,
// since the single shift register holds one count at a time
// reset: synchronous active-low rst_n clears history, index, state and output valid
`default_nettype none

module rle_count_string_encoder_core import rlecse_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel, one count per beat
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COUNT_BITS-1:0] in_run_count,
  input  wire logic                  in_first_of_mask,
  input  wire logic                  in_last_of_mask,
  // result channel, one character per beat
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [6:0]                 out_char_code,
  output logic                       out_last_of_count,
  output logic                       out_end_of_mask
);

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle until a count is taken, then one character per free output slot;
  // the final character frees the input in the same cycle
  rlecse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: history of two counts, saturating index, the count or at saturation its signed
  // difference to prev2 in a shift register drained five bits a character, and output payload
  rlecse_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .in_run_count     (in_run_count),
    .in_first_of_mask (in_first_of_mask),
    .in_last_of_mask  (in_last_of_mask),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .char_code        (out_char_code),
    .last_of_count    (out_last_of_count),
    .end_of_mask      (out_end_of_mask)
  );

endmodule

`default_nettype wire

/* src/rlecse_dp.sv */
// datapath: count history, difference, group shift register, output payload
// depends on rlecse_pkg
`default_nettype none

module rlecse_dp import rlecse_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic [COUNT_BITS-1:0] in_run_count,
  input  wire logic                  in_first_of_mask,
  input  wire logic                  in_last_of_mask,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output logic [6:0]                 char_code,
  output logic                       last_of_count,
  output logic                       end_of_mask
);

  localparam int unsigned DIFF_BITS = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] prev_r, prev_nxt;
  logic [COUNT_BITS-1:0] prev2_r, prev2_nxt;
  logic [1:0]            pos_r, pos_nxt;
  logic [DIFF_BITS-1:0]  x_r, x_nxt;
  logic                  last_r, last_nxt;
  logic [6:0]            char_r, char_nxt;
  logic                  loc_r, loc_nxt;
  logic                  eom_r, eom_nxt;

  logic [1:0]            pos_base;
  logic [COUNT_BITS-1:0] prev_base;
  logic [COUNT_BITS-1:0] prev2_base;
  logic [DIFF_BITS-1:0]  x_load;
  logic [DIFF_BITS-1:0]  x_shr;
  logic [4:0]            grp;
  logic                  more;

  always_comb begin
    // a new mask starts from empty history
    pos_base   = in_first_of_mask ? '0 : pos_r;
    prev_base  = in_first_of_mask ? '0 : prev_r;
    prev2_base = in_first_of_mask ? '0 : prev2_r;
    if (pos_base == POS_SAT) begin
      x_load = {1'b0, in_run_count} - {1'b0, prev2_base};
    end else begin
      x_load = {1'b0, in_run_count};
    end

    grp   = x_r[4:0];
    x_shr = DIFF_BITS'($signed(x_r) >>> GROUP_BITS);
    more  = grp[4] ? ~(&x_shr) : (|x_shr);

    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    pos_nxt   = pos_r;
    x_nxt     = x_r;
    last_nxt  = last_r;
    char_nxt  = char_r;
    loc_nxt   = loc_r;
    eom_nxt   = eom_r;

    if (cmd.emit) begin
      char_nxt = CHAR_BASE + {1'b0, more, grp};
      loc_nxt  = ~more;
      eom_nxt  = ~more & last_r;
      x_nxt    = x_shr;
    end
    // a load in the same cycle as the final character wins over the shift
    if (cmd.load) begin
      x_nxt     = x_load;
      last_nxt  = in_last_of_mask;
      prev_nxt  = in_run_count;
      prev2_nxt = prev_base;
      pos_nxt   = (pos_base == POS_SAT) ? POS_SAT : pos_base + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      prev2_r <= '0;
      pos_r   <= '0;
    end else begin
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    last_r <= last_nxt;
    char_r <= char_nxt;
    loc_r  <= loc_nxt;
    eom_r  <= eom_nxt;
  end

  assign sts.more      = more;
  assign char_code     = char_r;
  assign last_of_count = loc_r;
  assign end_of_mask   = eom_r;

endmodule

`default_nettype wire

/* src/rlecse_ctrl.sv */
// controller: idle/run sequencing, input stall and output valid
// depends on rlecse_pkg and the assertion macro header
`default_nettype none

`include "rle_count_string_encoder_core_assert.svh"

module rlecse_ctrl import rlecse_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_emit;
  logic   done;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    can_emit  = ~out_valid_r | ~out_stall;
    cmd.emit  = 1'b0;
    done      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_RUN: begin
        cmd.emit = can_emit;
        done     = can_emit & ~sts.more;
        in_stall = ~done;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    accept   = in_valid & ~in_stall;
    cmd.load = accept;

    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (done && !accept) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  assign out_valid = out_valid_r;

  `RLECSE_ASSERT_NOW(a_emit_only_running, cmd.emit, state_r == ST_RUN)
  `RLECSE_ASSERT_NOW(a_load_when_free, cmd.load, (state_r == ST_IDLE) || done)
  `RLECSE_ASSERT_NEXT(a_emit_shows_valid, cmd.emit, out_valid_r)
  `RLECSE_ASSERT_NEXT(a_load_starts_run, cmd.load, state_r == ST_RUN)

endmodule

`default_nettype wire
